[src/mwmm_pkg.sv]
// ----------------------------------------------------------------------------
// mwmm_pkg
// Shared widths, register indexes and reset values of the word masker.
// ----------------------------------------------------------------------------
package mwmm_pkg;

    localparam int CHAR_W        = 8;
    localparam int PATTERN_W     = 48;
    localparam int LEN_W         = 3;
    localparam int CFG_DATA_W    = 48;
    localparam int CFG_IDX_W     = 2;
    localparam int NUM_WORD_REGS = 2;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [CHAR_W-1:0]    MASK_CHAR      = 8'h23;
    localparam logic [PATTERN_W-1:0] WORD_A_RESET   = 48'h0000_7469_6873;
    localparam logic [PATTERN_W-1:0] WORD_B_RESET   = 48'h0000_6B63_7566;
    localparam logic [LEN_W-1:0]     WORD_LEN_RESET = 3'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WORD_A_PATTERN = 2'd0,
        REG_WORD_A_LENGTH  = 2'd1,
        REG_WORD_B_PATTERN = 2'd2,
        REG_WORD_B_LENGTH  = 2'd3
    } t_reg_idx;

endpackage

[src/mwmm_in_if.sv]
// ----------------------------------------------------------------------------
// mwmm_in_if
// Text input channel: one byte and its end-of-text flag per transfer.
// ----------------------------------------------------------------------------
interface mwmm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       end_of_text;

    modport source (output valid, output char_in, output end_of_text, input ready);
    modport sink   (input valid, input char_in, input end_of_text, output ready);
endinterface

[src/mwmm_out_if.sv]
// ----------------------------------------------------------------------------
// mwmm_out_if
// Text output channel: one masked byte with its flags per transfer.
// ----------------------------------------------------------------------------
interface mwmm_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_out;
    logic       was_masked;
    logic       last_out;

    modport source (output valid, output char_out, output was_masked, output last_out,
                    input ready);
    modport sink   (input valid, input char_out, input was_masked, input last_out,
                    output ready);
endinterface

[src/mwmm_front.sv]
// ----------------------------------------------------------------------------
// mwmm_front
// Word registers, byte window and match logic; turns each byte into an
// output job (one byte, a flush of the window, or nothing).
// ----------------------------------------------------------------------------
module mwmm_front #(
    parameter int MAX_WORD_LEN = 6,
    parameter int NUM_WORDS    = 2
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    mwmm_in_if.sink                             i_text,
    input  logic                                i_cfg_we,
    input  logic [mwmm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mwmm_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic                                o_job_valid,
    input  logic                                i_job_ready,
    output logic [MAX_WORD_LEN*8-1:0]           o_job_chars,
    output logic [MAX_WORD_LEN-1:0]             o_job_marks,
    output logic [$clog2(MAX_WORD_LEN+1)-1:0]   o_job_count,
    output logic                                o_job_flush
);
    import mwmm_pkg::*;

    localparam int POS_W      = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
    localparam int CNT_W      = $clog2(MAX_WORD_LEN + 1);
    localparam int USED_WORDS = (NUM_WORDS < NUM_WORD_REGS) ? NUM_WORDS : NUM_WORD_REGS;

    logic [PATTERN_W-1:0] r_pat [NUM_WORD_REGS];
    logic [LEN_W-1:0]     r_len [NUM_WORD_REGS];
    logic [CHAR_W-1:0]    r_win_bytes [MAX_WORD_LEN];
    logic                 r_win_marks [MAX_WORD_LEN];
    logic [POS_W-1:0]     r_fill;

    logic [CHAR_W-1:0]    ext_b [MAX_WORD_LEN];
    logic                 ext_m [MAX_WORD_LEN];
    logic                 new_m [MAX_WORD_LEN];
    logic [NUM_WORD_REGS-1:0] word_hit;
    logic                 win_full;
    logic                 xfer;
    logic [POS_W-1:0]     n_fill;

    assign win_full = (r_fill == POS_W'(MAX_WORD_LEN - 1));
    assign xfer     = i_text.valid && i_text.ready;

    always_comb begin
        for (int p = 0; p < MAX_WORD_LEN; p++) begin
            if (POS_W'(p) == r_fill) begin
                ext_b[p] = i_text.char_in;
                ext_m[p] = 1'b0;
            end else begin
                ext_b[p] = r_win_bytes[p];
                ext_m[p] = r_win_marks[p];
            end
        end
    end

    // newest len bytes against each word
    always_comb begin
        int  idx;
        int  fill_i;
        logic ok;
        fill_i = int'(r_fill);
        idx    = 0;
        ok     = 1'b0;
        for (int w = 0; w < NUM_WORD_REGS; w++) begin
            word_hit[w] = 1'b0;
            for (int len = 1; len <= MAX_WORD_LEN; len++) begin
                if (w < USED_WORDS && r_len[w] == LEN_W'(len) && len <= fill_i + 1) begin
                    ok = 1'b1;
                    for (int i = 0; i < len; i++) begin
                        idx = fill_i + 1 - len + i;
                        if (ext_b[POS_W'(idx)] != r_pat[w][8*i +: 8]) begin
                            ok = 1'b0;
                        end
                    end
                    word_hit[w] = ok;
                end
            end
        end
    end

    always_comb begin
        logic hit;
        for (int p = 0; p < MAX_WORD_LEN; p++) begin
            hit = 1'b0;
            for (int w = 0; w < NUM_WORD_REGS; w++) begin
                if (word_hit[w] && p <= int'(r_fill) && p + int'(r_len[w]) > int'(r_fill)) begin
                    hit = 1'b1;
                end
            end
            new_m[p] = ext_m[p] | hit;
            o_job_chars[8*p +: 8] = new_m[p] ? MASK_CHAR : ext_b[p];
            o_job_marks[p]        = new_m[p];
        end
    end

    assign i_text.ready = i_job_ready;
    assign o_job_valid  = i_text.valid && (i_text.end_of_text || win_full);
    assign o_job_flush  = i_text.end_of_text;
    assign o_job_count  = i_text.end_of_text ? CNT_W'(int'(r_fill) + 1) : CNT_W'(1);

    always_comb begin
        if (i_text.end_of_text) begin
            n_fill = '0;
        end else if (win_full) begin
            n_fill = r_fill;
        end else begin
            n_fill = r_fill + POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat[0] <= WORD_A_RESET;
            r_len[0] <= WORD_LEN_RESET;
            r_pat[1] <= WORD_B_RESET;
            r_len[1] <= WORD_LEN_RESET;
            r_fill   <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_WORD_A_PATTERN: r_pat[0] <= i_cfg_data[PATTERN_W-1:0];
                    REG_WORD_A_LENGTH:  r_len[0] <= i_cfg_data[LEN_W-1:0];
                    REG_WORD_B_PATTERN: r_pat[1] <= i_cfg_data[PATTERN_W-1:0];
                    REG_WORD_B_LENGTH:  r_len[1] <= i_cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end
            if (xfer) begin
                r_fill <= n_fill;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (xfer && !i_text.end_of_text) begin
            if (win_full) begin
                for (int p = 0; p < MAX_WORD_LEN - 1; p++) begin
                    r_win_bytes[p] <= ext_b[p+1];
                    r_win_marks[p] <= new_m[p+1];
                end
            end else begin
                for (int p = 0; p < MAX_WORD_LEN; p++) begin
                    r_win_bytes[p] <= ext_b[p];
                    r_win_marks[p] <= new_m[p];
                end
            end
        end
    end

endmodule

[src/mwmm_queue.sv]
// ----------------------------------------------------------------------------
// mwmm_queue
// Small register FIFO holding output jobs between front and back.
// ----------------------------------------------------------------------------
module mwmm_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output logic [WIDTH-1:0] o_pop_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

[src/mwmm_back.sv]
// ----------------------------------------------------------------------------
// mwmm_back
// Output sequencer: shifts the bytes of one job out, one per transfer.
// ----------------------------------------------------------------------------
module mwmm_back #(
    parameter int MAX_WORD_LEN = 6
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_job_valid,
    output logic                                o_job_ready,
    input  logic [MAX_WORD_LEN*8-1:0]           i_job_chars,
    input  logic [MAX_WORD_LEN-1:0]             i_job_marks,
    input  logic [$clog2(MAX_WORD_LEN+1)-1:0]   i_job_count,
    input  logic                                i_job_flush,
    mwmm_out_if.source                          o_text
);
    localparam int CNT_W = $clog2(MAX_WORD_LEN + 1);

    logic [MAX_WORD_LEN*8-1:0] r_chars;
    logic [MAX_WORD_LEN-1:0]   r_marks;
    logic [CNT_W-1:0]          r_left;
    logic                      r_flush;
    logic                      xfer;
    logic                      load;

    assign xfer        = o_text.valid && o_text.ready;
    assign load        = (r_left == '0) || (r_left == CNT_W'(1) && xfer);
    assign o_job_ready = load;

    assign o_text.valid      = (r_left != '0);
    assign o_text.char_out   = r_chars[7:0];
    assign o_text.was_masked = r_marks[0];
    assign o_text.last_out   = r_flush && (r_left == CNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (load) begin
            r_left <= i_job_valid ? i_job_count : '0;
        end else if (xfer) begin
            r_left <= r_left - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_job_valid) begin
            r_chars <= i_job_chars;
            r_marks <= i_job_marks;
            r_flush <= i_job_flush;
        end else if (xfer) begin
            r_chars <= r_chars >> 8;
            r_marks <= r_marks >> 1;
        end
    end

endmodule

[src/multi_word_match_and_mask.sv]
// ----------------------------------------------------------------------------
// multi_word_match_and_mask
// Streaming masker: bytes that form a configured word leave as '#'.
// ----------------------------------------------------------------------------
// One text byte is taken per cycle, held off once the two-entry job queue is
// full, and once the window of MAX_WORD_LEN-1 bytes is full, one byte leaves
// per cycle while o_text is ready, so a steady stream runs at one byte per
// clock; a byte pushed out of the window is registered in the job queue, then
// in the output sequencer. A byte with end_of_text set releases the whole
// window (up to MAX_WORD_LEN bytes), sent one per cycle while o_text is ready.
// Word registers must be written through the plain write port while the
// stream is idle; the block itself does not enforce this.
module multi_word_match_and_mask #(
    parameter int MAX_WORD_LEN = 6,
    parameter int NUM_WORDS    = 2
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    mwmm_in_if.sink                             i_text,
    mwmm_out_if.source                          o_text,
    input  logic                                i_cfg_we,
    input  logic [mwmm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mwmm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import mwmm_pkg::*;

    localparam int CNT_W = $clog2(MAX_WORD_LEN + 1);
    localparam int JOB_W = MAX_WORD_LEN * 8 + MAX_WORD_LEN + CNT_W + 1;

    logic                      fr_valid;
    logic                      fr_ready;
    logic [MAX_WORD_LEN*8-1:0] fr_chars;
    logic [MAX_WORD_LEN-1:0]   fr_marks;
    logic [CNT_W-1:0]          fr_count;
    logic                      fr_flush;

    logic                      bk_valid;
    logic                      bk_ready;
    logic [MAX_WORD_LEN*8-1:0] bk_chars;
    logic [MAX_WORD_LEN-1:0]   bk_marks;
    logic [CNT_W-1:0]          bk_count;
    logic                      bk_flush;
    logic [JOB_W-1:0]          q_out;

    mwmm_front #(
        .MAX_WORD_LEN (MAX_WORD_LEN),
        .NUM_WORDS    (NUM_WORDS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_text      (i_text),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_job_valid (fr_valid),
        .i_job_ready (fr_ready),
        .o_job_chars (fr_chars),
        .o_job_marks (fr_marks),
        .o_job_count (fr_count),
        .o_job_flush (fr_flush)
    );

    mwmm_queue #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (fr_valid),
        .o_push_ready (fr_ready),
        .i_push_data  ({fr_flush, fr_count, fr_marks, fr_chars}),
        .o_pop_valid  (bk_valid),
        .i_pop_ready  (bk_ready),
        .o_pop_data   (q_out)
    );

    assign {bk_flush, bk_count, bk_marks, bk_chars} = q_out;

    mwmm_back #(
        .MAX_WORD_LEN (MAX_WORD_LEN)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (bk_valid),
        .o_job_ready (bk_ready),
        .i_job_chars (bk_chars),
        .i_job_marks (bk_marks),
        .i_job_count (bk_count),
        .i_job_flush (bk_flush),
        .o_text      (o_text)
    );

    a_job_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fr_valid && fr_ready) |-> (fr_count != '0 && fr_count <= CNT_W'(MAX_WORD_LEN)))
        else $error("job count out of range");

    a_single_byte_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fr_valid && fr_ready && !fr_flush) |-> (fr_count == CNT_W'(1)))
        else $error("steady job carries more than one byte");

    a_mask_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_text.valid && o_text.was_masked) |-> (o_text.char_out == MASK_CHAR))
        else $error("masked byte not replaced");

    a_transfer_only_with_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_text.valid && i_text.ready && (i_text.end_of_text || fr_valid)) |-> fr_ready)
        else $error("input transfer without queue room");

endmodule
